// ----- rtl/core/vpn_handshake_classifier_core_defines.svh -----
// Assertion macros for the handshake classifier checkers.
// Each expects signals clk and arst_n in the scope of use.
`ifndef VPN_HANDSHAKE_CLASSIFIER_CORE_DEFINES_SVH
`define VPN_HANDSHAKE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication.
`define VHC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/vhc_pkg.sv -----
`timescale 1ns / 1ps
package vhc_pkg;

	// Parser phases
	localparam logic [3:0] PH_START   = 4'd0;
	localparam logic [3:0] PH_A_SP0   = 4'd1;
	localparam logic [3:0] PH_A_TOK   = 4'd2;
	localparam logic [3:0] PH_A_TXT   = 4'd3;
	localparam logic [3:0] PH_A_ONE   = 4'd4;
	localparam logic [3:0] PH_A_SEV   = 4'd5;
	localparam logic [3:0] PH_A_NL    = 4'd6;
	localparam logic [3:0] PH_A_END   = 4'd7;
	localparam logic [3:0] PH_B_SP0   = 4'd8;
	localparam logic [3:0] PH_B_TOK   = 4'd9;
	localparam logic [3:0] PH_B_DIG   = 4'd10;
	localparam logic [3:0] PH_B_TAIL  = 4'd11;
	localparam logic [3:0] PH_B_END   = 4'd12;

	// Characters
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_1  = 8'h31;
	localparam logic [7:0] CH_7  = 8'h37;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_Z  = 8'h5A;

	localparam logic [2:0]  GROUPS    = 3'd4;
	localparam logic [15:0] MIN_LEN_A = 16'd6;
	localparam logic [15:0] MIN_LEN_B = 16'd11;
	localparam logic [1:0]  FS_LAST   = 2'd3;
	localparam logic [2:0]  FS_DET    = 3'd4;

	// Verdict codes
	localparam logic [2:0] VERD_PEND  = 3'd0;
	localparam logic [2:0] VERD_ADV   = 3'd1;
	localparam logic [2:0] VERD_HS    = 3'd2;
	localparam logic [2:0] VERD_CACHE = 3'd3;
	localparam logic [2:0] VERD_EXCL  = 3'd4;

	localparam int STAMP_W = 40;
	localparam int KEY_W   = 80;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic                valid;
		logic [STAMP_W-1:0]  stamp;
		key_t                key;
	} cache_word_t;

	typedef struct packed {
		logic start;
		logic take;
		key_t key1;
		key_t key2;
	} cache_req_t;

	typedef struct packed {
		logic ready;
		logic done;
		logic hit;
	} cache_rsp_t;

	typedef struct packed {
		logic pass;
	} parse_res_t;

endpackage

// ----- rtl/core/vhc_in_if.sv -----
`timescale 1ns / 1ps
interface vhc_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        last_byte;
	logic [1:0]  flow_state_in;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] src_port;
	logic [15:0] srv_port;

	modport source (output valid, cmd, data_byte, first_byte, last_byte, flow_state_in,
		src_addr, dst_addr, src_port, srv_port, input ready);
	modport sink (input valid, cmd, data_byte, first_byte, last_byte, flow_state_in,
		src_addr, dst_addr, src_port, srv_port, output ready);
endinterface

// ----- rtl/core/vhc_out_if.sv -----
`timescale 1ns / 1ps
interface vhc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic [2:0] flow_state_out;

	modport source (output valid, verdict, flow_state_out, input ready);
	modport sink (input valid, verdict, flow_state_out, output ready);
endinterface

// ----- rtl/core/vhc_parser.sv -----
`timescale 1ns / 1ps
module vhc_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              first_byte,
	input  logic              last_byte,
	input  logic [1:0]        flow_state_in,
	output vhc_pkg::parse_res_t res
);
	import vhc_pkg::*;

	logic [3:0]  phase_q;
	logic [15:0] cnt_q;
	logic [2:0]  groups_q;
	logic        seen_q;
	logic        fail_q;

	logic [3:0]  ph, next, ph_n;
	logic [15:0] cnt, cnt_n;
	logic [2:0]  gl, gl_n;
	logic        seen, seen_n, fail, fail_n, bad;
	logic        gram_a, gram_b;

	// Byte grammar step; a first-marked byte starts from a clean parser
	always_comb begin
		ph     = first_byte ? PH_START : phase_q;
		cnt    = first_byte ? 16'd0 : cnt_q;
		gl     = first_byte ? GROUPS : groups_q;
		seen   = first_byte ? 1'b0 : seen_q;
		fail   = first_byte ? 1'b0 : fail_q;
		cnt_n  = (cnt != 16'hFFFF) ? cnt + 16'd1 : cnt;
		next   = ph;
		bad    = 1'b0;
		gl_n   = gl;
		seen_n = seen;
		if (!fail) begin
			case (ph)
				PH_START: begin
					if (flow_state_in < 2'd2) begin
						if (data_byte == CH_0) next = PH_A_SP0; else bad = 1'b1;
					end else begin
						if (data_byte == CH_1) next = PH_B_SP0; else bad = 1'b1;
					end
				end
				PH_A_SP0: if (data_byte == CH_SP) next = PH_A_TOK; else bad = 1'b1;
				PH_A_TOK: if (data_byte != CH_SP) next = PH_A_TXT; else bad = 1'b1;
				PH_A_TXT: if (data_byte == CH_SP) next = PH_A_ONE;
				PH_A_ONE: if (data_byte == CH_1) next = PH_A_SEV; else bad = 1'b1;
				PH_A_SEV: if (data_byte == CH_7) next = PH_A_NL; else bad = 1'b1;
				PH_A_NL: begin
					if (data_byte == CH_NL) begin
						next   = PH_A_END;
						seen_n = 1'b1;
					end else bad = 1'b1;
				end
				PH_A_END: bad = 1'b1;
				PH_B_SP0: if (data_byte == CH_SP) next = PH_B_TOK; else bad = 1'b1;
				PH_B_TOK: if (data_byte != CH_SP) next = PH_B_DIG; else bad = 1'b1;
				PH_B_DIG: begin
					if (data_byte == CH_SP) begin
						if (gl <= 3'd1) begin
							gl_n = 3'd0;
							next = PH_B_TAIL;
						end else gl_n = gl - 3'd1;
					end else if (!(data_byte inside {[CH_0:CH_9]})) bad = 1'b1;
				end
				PH_B_TAIL: begin
					if (data_byte == CH_NL) begin
						next   = PH_B_END;
						seen_n = 1'b1;
					end else if (!(data_byte inside {[CH_0:CH_9], [CH_A:CH_Z]})) bad = 1'b1;
				end
				PH_B_END: ;
				default: bad = 1'b1;
			endcase
		end
		fail_n = fail | bad;
		ph_n   = bad ? ph : next;
		gram_a = ph_n inside {[PH_A_SP0:PH_A_END]};
		gram_b = ph_n inside {[PH_B_SP0:PH_B_END]};
		if (gram_a)
			res.pass = !fail_n && seen_n && (flow_state_in < 2'd2) && (cnt_n > MIN_LEN_A);
		else if (gram_b)
			res.pass = !fail_n && seen_n && (flow_state_in >= 2'd2) && (cnt_n > MIN_LEN_B);
		else
			res.pass = 1'b0;
	end

	// Parser state; restarts after a last-marked byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			cnt_q    <= '0;
			groups_q <= GROUPS;
			seen_q   <= 1'b0;
			fail_q   <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				phase_q  <= PH_START;
				cnt_q    <= '0;
				groups_q <= GROUPS;
				seen_q   <= 1'b0;
				fail_q   <= 1'b0;
			end else begin
				phase_q  <= ph_n;
				cnt_q    <= cnt_n;
				groups_q <= gl_n;
				seen_q   <= seen_n;
				fail_q   <= fail_n;
			end
		end
	end
endmodule

// ----- rtl/core/vhc_cache.sv -----
`timescale 1ns / 1ps
module vhc_cache #(
	parameter int ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vhc_pkg::cache_req_t req,
	output vhc_pkg::cache_rsp_t rsp
);
	import vhc_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	typedef enum logic [4:0] {
		C_CLR   = 5'b00001,
		C_IDLE  = 5'b00010,
		C_SWEEP = 5'b00100,
		C_WR1   = 5'b01000,
		C_WR2   = 5'b10000
	} cst_t;

	cache_word_t mem [ENTRIES];
	cache_word_t rd_q;
	cache_word_t wd;
	logic [AW-1:0] wa;
	logic          we;

	cst_t          st_q;
	logic [AW-1:0] cnt_q;
	logic          iss_done_q;
	logic          sv_s1;
	logic [AW-1:0] idx_s1;
	logic          take_q;
	key_t          key1_q, key2_q;
	logic          m1_q, m2_q, fr_q, old_q;
	logic [AW-1:0] m1i_q, m2i_q, fri_q, oldi_q;
	logic [STAMP_W-1:0] olds_q, stamp_q;

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[cnt_q];
	end

	// Write port select
	always_comb begin
		we = 1'b0;
		wa = cnt_q;
		wd = '0;
		case (st_q)
			C_CLR: we = 1'b1;
			C_WR1: begin
				if (take_q) begin
					we = m1_q;
					wa = m1i_q;
				end else begin
					we       = 1'b1;
					wa       = m1_q ? m1i_q : (fr_q ? fri_q : oldi_q);
					wd.valid = 1'b1;
					wd.stamp = stamp_q;
					wd.key   = key1_q;
				end
			end
			C_WR2: begin
				we = take_q & m2_q;
				wa = m2i_q;
			end
			default: ;
		endcase
	end

	assign rsp.ready = (st_q == C_IDLE);
	assign rsp.done  = (st_q == C_WR2);
	assign rsp.hit   = m1_q | m2_q;

	// Clearing pass, search sweep and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= C_CLR;
			cnt_q      <= '0;
			iss_done_q <= 1'b0;
			sv_s1      <= 1'b0;
			stamp_q    <= '0;
			m1_q       <= 1'b0;
			m2_q       <= 1'b0;
			fr_q       <= 1'b0;
			old_q      <= 1'b0;
		end else begin
			sv_s1  <= (st_q == C_SWEEP) && !iss_done_q;
			idx_s1 <= cnt_q;
			case (st_q)
				C_CLR: begin
					if (cnt_q == LAST) st_q <= C_IDLE;
					else cnt_q <= cnt_q + 1'b1;
				end
				C_IDLE: begin
					if (req.start) begin
						st_q       <= C_SWEEP;
						cnt_q      <= '0;
						iss_done_q <= 1'b0;
						take_q     <= req.take;
						key1_q     <= req.key1;
						key2_q     <= req.key2;
						m1_q       <= 1'b0;
						m2_q       <= 1'b0;
						fr_q       <= 1'b0;
						old_q      <= 1'b0;
					end
				end
				C_SWEEP: begin
					if (!iss_done_q) begin
						if (cnt_q == LAST) iss_done_q <= 1'b1;
						else cnt_q <= cnt_q + 1'b1;
					end
					if (sv_s1) begin
						if (rd_q.valid) begin
							if (rd_q.key == key1_q) begin
								m1_q  <= 1'b1;
								m1i_q <= idx_s1;
							end
							if (take_q && rd_q.key == key2_q) begin
								m2_q  <= 1'b1;
								m2i_q <= idx_s1;
							end
							if (!old_q || rd_q.stamp < olds_q) begin
								old_q  <= 1'b1;
								oldi_q <= idx_s1;
								olds_q <= rd_q.stamp;
							end
						end else if (!fr_q) begin
							fr_q  <= 1'b1;
							fri_q <= idx_s1;
						end
						if (idx_s1 == LAST) st_q <= C_WR1;
					end
				end
				C_WR1: begin
					if (!take_q) stamp_q <= stamp_q + 1'b1;
					st_q <= C_WR2;
				end
				C_WR2: st_q <= C_IDLE;
				default: st_q <= C_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/vpn_handshake_classifier_core.sv -----
`timescale 1ns / 1ps
// TCP payload bytes: a new byte is taken whenever req.ready is high, and the result
// is registered the cycle after the transfer. UDP lookups and the final handshake
// pass run a one-entry-per-cycle sweep of the cache memory through its registered
// read port, then the write-back states C_WR1 and C_WR2.
// Reset (arst_n low, asynchronous) clears the parser; afterwards a clearing pass runs
// over every cache memory entry and no input is taken meanwhile.
module vpn_handshake_classifier_core #(
	parameter int CACHE_ENTRIES = 64
) (
	input logic    clk,
	input logic    arst_n,
	vhc_in_if.sink   req,
	vhc_out_if.source rsp
);
	import vhc_pkg::*;

	parse_res_t pres;
	cache_req_t creq;
	cache_rsp_t crsp;

	logic       accept, tcp_step, do_insert;
	logic       wait_q, out_v_q;
	logic [2:0] verdict_q, fso_q;
	logic [1:0] fs_q;
	logic       take_q;
	logic [2:0] tcp_verdict, tcp_fso;

	vhc_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (tcp_step),
		.data_byte    (req.data_byte),
		.first_byte   (req.first_byte),
		.last_byte    (req.last_byte),
		.flow_state_in(req.flow_state_in),
		.res          (pres)
	);

	vhc_cache #(.ENTRIES(CACHE_ENTRIES)) u_cache (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (creq),
		.rsp   (crsp)
	);

	assign req.ready = !wait_q && crsp.ready && (!out_v_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign tcp_step  = accept && !req.cmd;
	assign do_insert = req.last_byte && pres.pass && (req.flow_state_in == FS_LAST);

	assign creq.start = accept && (req.cmd || do_insert);
	assign creq.take  = req.cmd;
	assign creq.key1  = {req.src_addr, req.dst_addr, req.srv_port};
	assign creq.key2  = {req.dst_addr, req.src_addr, req.src_port};

	// Verdict for a TCP byte that needs no cache access
	always_comb begin
		tcp_fso = {1'b0, req.flow_state_in};
		if (!req.last_byte) tcp_verdict = VERD_PEND;
		else if (!pres.pass) tcp_verdict = VERD_EXCL;
		else begin
			tcp_verdict = VERD_ADV;
			tcp_fso     = {1'b0, req.flow_state_in} + 3'd1;
		end
	end

	// Result register and cache wait
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (wait_q && crsp.done) begin
				wait_q  <= 1'b0;
				out_v_q <= 1'b1;
				if (!take_q) begin
					verdict_q <= VERD_HS;
					fso_q     <= FS_DET;
				end else if (crsp.hit) begin
					verdict_q <= VERD_CACHE;
					fso_q     <= FS_DET;
				end else begin
					verdict_q <= VERD_EXCL;
					fso_q     <= {1'b0, fs_q};
				end
			end else begin
				if (creq.start) begin
					wait_q <= 1'b1;
					take_q <= req.cmd;
					fs_q   <= req.flow_state_in;
				end
				if (tcp_step && !creq.start) begin
					out_v_q   <= 1'b1;
					verdict_q <= tcp_verdict;
					fso_q     <= tcp_fso;
				end else if (rsp.ready) out_v_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.verdict        = verdict_q;
	assign rsp.flow_state_out = fso_q;
endmodule

// ----- rtl/core/vhc_checker.sv -----
`timescale 1ns / 1ps
`include "vpn_handshake_classifier_core_defines.svh"
module vhc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] verdict,
	input logic [2:0] flow_state_out
);
	import vhc_pkg::*;

	logic is_det;

	assign is_det = rsp_valid && (verdict == VERD_HS || verdict == VERD_CACHE);

	// A stalled result keeps its verdict
	`VHC_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(verdict), "lost hold")
	// Detections always report the detected flow state
	`VHC_ASSERT_IMPL(a_det, is_det, flow_state_out == FS_DET, "detection without detected state")
	// An advance lands in states one to three
	`VHC_ASSERT_IMPL(a_adv, rsp_valid && verdict == VERD_ADV, flow_state_out < FS_DET, "bad advance")
	// Verdict stays within its codes
	`VHC_ASSERT_IMPL(a_code, rsp_valid, verdict <= VERD_EXCL, "verdict out of range")
endmodule

bind vpn_handshake_classifier_core vhc_checker u_vhc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.verdict       (rsp.verdict),
	.flow_state_out(rsp.flow_state_out)
);
